// ===== src/cptm_pkg.sv =====
// ----------------------------------------------------------------------------
// cptm_pkg: shared types and constants for the closest-point block
// Field widths, datapath widths and the request words that pass between
// the sequencer, the multiply-accumulate unit and the fraction divider.
// ----------------------------------------------------------------------------
package cptm_pkg;

  localparam int CW    = 16;        // input coordinate, Q8.8
  localparam int EW    = CW + 1;    // edge and offset vectors, Q9.8
  localparam int DOTW  = 36;        // dot products a..e, Q20.16
  localparam int ACCW  = 72;        // accumulator, det, s and t
  localparam int XW    = DOTW;      // wide multiplier operand
  localparam int SPLIT = 19;        // low slice of a split operand
  localparam int YW    = SPLIT + 1; // narrow multiplier operand
  localparam int SHW   = 5;         // product shift amount
  localparam int FW    = 17;        // Q0.16 fraction including 1.0
  localparam int OW    = 24;        // output point, Q8.16
  localparam int DSW   = 52;        // squared distance, Q20.32
  localparam int IW    = 2;         // register index

  localparam logic [FW-1:0]  ONE_Q16  = 17'h10000;
  localparam logic [DSW-1:0] DIST_MAX = {DSW{1'b1}};

  localparam logic [IW-1:0] REG_QX = 2'd0;
  localparam logic [IW-1:0] REG_QY = 2'd1;
  localparam logic [IW-1:0] REG_QZ = 2'd2;

  // one multiply-accumulate step: acc = (clr ? 0 : acc) +/- (x * y) << sh
  typedef struct packed {
    logic                  clr;
    logic                  neg;
    logic signed [XW-1:0]  x;
    logic signed [YW-1:0]  y;
    logic [SHW-1:0]        sh;
  } mac_op_t;

  typedef struct packed {
    logic                   start;
    logic signed [ACCW-1:0] num;
    logic signed [ACCW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [FW-1:0] q;
  } div_rsp_t;

endpackage

// ===== src/cptm_ifs.sv =====
// ----------------------------------------------------------------------------
// cptm_ifs: channel interfaces
// Triangle input, result output and register write channels, each with
// valid, ready and its payload.
// ----------------------------------------------------------------------------
interface cptm_tri_if import cptm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] a_x, a_y, a_z;
  logic signed [CW-1:0] b_x, b_y, b_z;
  logic signed [CW-1:0] c_x, c_y, c_z;
  logic                 last_triangle;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  last_triangle, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                last_triangle, output ready);
endinterface

interface cptm_res_if import cptm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] near_x, near_y, near_z;
  logic [DSW-1:0]       dist_squared;

  modport source (output valid, near_x, near_y, near_z, dist_squared, input ready);
  modport sink (input valid, near_x, near_y, near_z, dist_squared, output ready);
endinterface

interface cptm_cfg_if import cptm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [IW-1:0]        index;
  logic signed [CW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/cptm_mac.sv =====
// ----------------------------------------------------------------------------
// cptm_mac: shared multiply-accumulate unit
// One signed product a cycle, shifted and added to or taken from the
// accumulator. Wide products are built from two steps on split operands.
// ----------------------------------------------------------------------------
module cptm_mac import cptm_pkg::*; (
  input  logic                   clk,
  input  mac_op_t                op,
  output logic signed [ACCW-1:0] acc
);

  logic signed [XW+YW-1:0] prod;
  logic signed [ACCW-1:0]  term;
  logic signed [ACCW-1:0]  base;
  logic signed [ACCW-1:0]  acc_r, acc_nxt;

  always_comb begin
    prod    = op.x * op.y;
    term    = ACCW'(prod) <<< op.sh;
    base    = op.clr ? '0 : acc_r;
    acc_nxt = op.neg ? base - term : base + term;
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== src/cptm_div.sv =====
// ----------------------------------------------------------------------------
// cptm_div: Q0.16 fraction divider
// Restoring division, one quotient bit a cycle. Result is clamped to [0,1]:
// zero for a non-positive numerator or divisor, one when num >= den.
// ----------------------------------------------------------------------------
module cptm_div import cptm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int RW   = ACCW + 1;
  localparam int ITER = FW - 1;
  localparam int CNTW = $clog2(ITER);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNTW-1:0]     cnt_r, cnt_nxt;
  logic [RW-1:0]       rem_r, rem_nxt, rem_sh, dvs;
  logic [ACCW-1:0]     den_r, den_nxt;
  logic [FW-1:0]       q_r, q_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    rem_sh   = {rem_r[RW-2:0], 1'b0};
    dvs      = {1'b0, den_r};
    if (req.start) begin
      if (req.den <= 0 || req.num <= 0) begin
        q_nxt    = '0;
        done_nxt = 1'b1;
      end else if (req.num >= req.den) begin
        q_nxt    = ONE_Q16;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        cnt_nxt  = '0;
        rem_nxt  = {1'b0, req.num};
        den_nxt  = req.den;
        q_nxt    = '0;
      end
    end else if (busy_r) begin
      if (rem_sh >= dvs) begin
        rem_nxt = rem_sh - dvs;
        q_nxt   = {q_r[FW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[FW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(ITER - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;

endmodule

// ===== src/closest_point_on_triangle_mesh.sv =====
// ----------------------------------------------------------------------------
// closest_point_on_triangle_mesh: nearest point on a triangle stream
// Keeps the closest point seen on a mesh to a query point and emits it
// with its squared distance on the triangle marked last.
// ----------------------------------------------------------------------------
// in_tri.ready is low while a triangle is in work, which lasts longer when
// the nearest point lies inside the triangle, as that needs two divisions.
// The work is done by the single shared multiply-accumulate unit, which
// forms one product a cycle (the dot products and the 72-bit det, s and t
// terms, then the point and its squared distance), and by the radix-2
// divider, which forms each Q0.16 fraction bit by bit unless it clamps. A
// finished result waits in an output register, so the next triangle is
// taken while it is still unread. cfg_wr.ready is always high; the user must
// write the registers through cfg_wr only while idle, unenforced by the block.
module closest_point_on_triangle_mesh import cptm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  cptm_cfg_if.sink   cfg_wr,
  cptm_tri_if.sink   in_tri,
  cptm_res_if.source out_res
);

  localparam logic [4:0] DOT_LAST   = 5'd27;
  localparam logic [4:0] PLACE_LAST = 5'd15;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DOT, ST_DECIDE, ST_DIV1, ST_DIV2, ST_PLACE
  } state_t;

  typedef enum logic [2:0] {
    MD_S_ONLY, MD_T_ONLY, MD_BOTH, MD_S_COMP, MD_T_COMP
  } mode_t;

  state_t                 state_r;
  logic [4:0]             step_r;
  logic signed [CW-1:0]   q_r [3];
  logic signed [EW-1:0]   p_r [3];
  logic signed [EW-1:0]   e0_r [3];
  logic signed [EW-1:0]   e1_r [3];
  logic signed [EW-1:0]   v_r [3];
  logic                   last_r;
  logic signed [DOTW-1:0] a_r, b_r, c_r, d_r, e_r;
  logic signed [ACCW-1:0] det_r, s_r, t_r;
  mode_t                  mode_r, dec_mode;
  logic [FW-1:0]          f1_r, sq_r, tq_r;
  logic signed [OW-1:0]   nr_r [3];
  logic signed [OW:0]     df_r [3];
  logic [DSW-1:0]         best_d_r;
  logic signed [OW-1:0]   best_x_r, best_y_r, best_z_r;
  logic                   out_valid_r;
  logic [DSW-1:0]         out_d_r;
  logic signed [OW-1:0]   out_x_r, out_y_r, out_z_r;

  mac_op_t                op;
  logic signed [ACCW-1:0] acc;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  logic                   in_acc;
  logic [1:0]             k, pc, sel, cap_c;
  logic signed [XW-1:0]   p_s, e0_s, e1_s, v_s, df_s, q_cap;
  logic signed [ACCW-1:0] ax, bx, cx, dx, ex, num1, num2, den;
  logic signed [ACCW:0]   st_sum;
  logic                   lt_det;
  logic signed [ACCW-1:0] dec_num, dec_den;
  logic signed [OW-1:0]   nr_new;
  logic signed [OW:0]     df_new;
  logic [DSW-1:0]         dist_new, nb_d;
  logic                   better, fin_block, emit;

  function automatic logic [1:0] mod3(input logic [3:0] n);
    logic [1:0] r;
    case (n) inside
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
      default:                              r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic signed [XW-1:0] pick(input logic signed [XW-1:0] v0,
                                                input logic signed [XW-1:0] v1,
                                                input logic signed [XW-1:0] v2,
                                                input logic [1:0] s);
    logic signed [XW-1:0] r;
    case (s)
      2'd0:    r = v0;
      2'd1:    r = v1;
      default: r = v2;
    endcase
    return r;
  endfunction

  function automatic logic signed [YW-1:0] lo_part(input logic signed [XW-1:0] v);
    return $signed({1'b0, v[SPLIT-1:0]});
  endfunction

  function automatic logic signed [YW-1:0] hi_part(input logic signed [XW-1:0] v);
    return YW'(v >>> SPLIT);
  endfunction

  // floor from Q.24 to Q8.16 and clip to the output range
  function automatic logic signed [OW-1:0] sat_pt(input logic signed [ACCW-1:0] v);
    logic signed [ACCW-1:0] sh;
    logic signed [OW-1:0]   r;
    sh = v >>> 8;
    if (&sh[ACCW-1:OW-1] || ~|sh[ACCW-1:OW-1]) begin
      r = sh[OW-1:0];
    end else if (sh[ACCW-1]) begin
      r = {1'b1, {(OW-1){1'b0}}};
    end else begin
      r = {1'b0, {(OW-1){1'b1}}};
    end
    return r;
  endfunction

  cptm_mac u_mac (
    .clk (clk),
    .op  (op),
    .acc (acc)
  );

  cptm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tri.ready = (state_r == ST_IDLE);
  assign in_acc       = in_tri.valid && in_tri.ready;
  assign cfg_wr.ready = 1'b1;

  assign out_res.valid        = out_valid_r;
  assign out_res.near_x       = out_x_r;
  assign out_res.near_y       = out_y_r;
  assign out_res.near_z       = out_z_r;
  assign out_res.dist_squared = out_d_r;

  // operand selection for the shared multiplier
  always_comb begin
    k = mod3(step_r[3:0]);
    case (step_r) inside
      [5'd0:5'd2], [5'd9:5'd10]:  pc = 2'd0;
      [5'd3:5'd5], [5'd11:5'd12]: pc = 2'd1;
      default:                    pc = 2'd2;
    endcase
    sel  = (state_r == ST_PLACE) ? pc : k;
    p_s  = pick(XW'(p_r[0]), XW'(p_r[1]), XW'(p_r[2]), sel);
    e0_s = pick(XW'(e0_r[0]), XW'(e0_r[1]), XW'(e0_r[2]), sel);
    e1_s = pick(XW'(e1_r[0]), XW'(e1_r[1]), XW'(e1_r[2]), sel);
    v_s  = pick(XW'(v_r[0]), XW'(v_r[1]), XW'(v_r[2]), sel);
    df_s = pick(XW'(df_r[0]), XW'(df_r[1]), XW'(df_r[2]), sel);

    op = '0;
    if (state_r == ST_DOT) begin
      op.clr = (step_r < 5'd15) && (k == 2'd0);
      case (step_r) inside
        [5'd0:5'd2]:   begin op.x = e0_s; op.y = YW'(e0_s); end
        [5'd3:5'd5]:   begin op.x = e0_s; op.y = YW'(e1_s); end
        [5'd6:5'd8]:   begin op.x = e1_s; op.y = YW'(e1_s); end
        [5'd9:5'd11]:  begin op.x = e0_s; op.y = YW'(v_s); end
        [5'd12:5'd14]: begin op.x = e1_s; op.y = YW'(v_s); end
        5'd15: begin op.clr = 1'b1; op.x = a_r; op.y = lo_part(c_r); end
        5'd16: begin op.x = a_r; op.y = hi_part(c_r); op.sh = SHW'(SPLIT); end
        5'd17: begin op.neg = 1'b1; op.x = b_r; op.y = lo_part(b_r); end
        5'd18: begin
          op.neg = 1'b1; op.x = b_r; op.y = hi_part(b_r); op.sh = SHW'(SPLIT);
        end
        5'd19: begin op.clr = 1'b1; op.x = b_r; op.y = lo_part(e_r); end
        5'd20: begin op.x = b_r; op.y = hi_part(e_r); op.sh = SHW'(SPLIT); end
        5'd21: begin op.neg = 1'b1; op.x = c_r; op.y = lo_part(d_r); end
        5'd22: begin
          op.neg = 1'b1; op.x = c_r; op.y = hi_part(d_r); op.sh = SHW'(SPLIT);
        end
        5'd23: begin op.clr = 1'b1; op.x = b_r; op.y = lo_part(d_r); end
        5'd24: begin op.x = b_r; op.y = hi_part(d_r); op.sh = SHW'(SPLIT); end
        5'd25: begin op.neg = 1'b1; op.x = a_r; op.y = lo_part(e_r); end
        5'd26: begin
          op.neg = 1'b1; op.x = a_r; op.y = hi_part(e_r); op.sh = SHW'(SPLIT);
        end
        default: ;
      endcase
    end else if (state_r == ST_PLACE) begin
      case (step_r) inside
        [5'd0:5'd8]: begin
          case (k)
            2'd0:    begin op.clr = 1'b1; op.x = p_s; op.y = YW'(ONE_Q16); end
            2'd1:    begin op.x = e0_s; op.y = YW'(sq_r); end
            default: begin op.x = e1_s; op.y = YW'(tq_r); end
          endcase
        end
        [5'd9:5'd14]: begin
          op.clr = (step_r == 5'd9);
          op.x   = df_s;
          if (step_r[0]) begin
            op.y = lo_part(df_s);
          end else begin
            op.y  = hi_part(df_s);
            op.sh = SHW'(SPLIT);
          end
        end
        default: ;
      endcase
    end
  end

  // region selection of the seven-region scheme
  always_comb begin
    ax     = ACCW'(a_r);
    bx     = ACCW'(b_r);
    cx     = ACCW'(c_r);
    dx     = ACCW'(d_r);
    ex     = ACCW'(e_r);
    num1   = (cx + ex) - (bx + dx);
    num2   = (ax + dx) - (bx + ex);
    den    = ax - (bx <<< 1) + cx;
    st_sum = (ACCW+1)'(s_r) + (ACCW+1)'(t_r);
    lt_det = st_sum < (ACCW+1)'(det_r);
    dec_mode = MD_S_ONLY;
    dec_num  = -dx;
    dec_den  = ax;
    if (lt_det) begin
      if (s_r[ACCW-1]) begin
        if (!(t_r[ACCW-1] && d_r[DOTW-1])) begin
          dec_mode = MD_T_ONLY; dec_num = -ex; dec_den = cx;
        end
      end else if (!t_r[ACCW-1]) begin
        dec_mode = MD_BOTH; dec_num = s_r; dec_den = det_r;
      end
    end else begin
      if (s_r[ACCW-1]) begin
        if (num1 > 0) begin
          dec_mode = MD_S_COMP; dec_num = num1; dec_den = den;
        end else begin
          dec_mode = MD_T_ONLY; dec_num = -ex; dec_den = cx;
        end
      end else if (t_r[ACCW-1]) begin
        if (num2 > 0) begin
          dec_mode = MD_T_COMP; dec_num = num2; dec_den = den;
        end
      end else begin
        dec_mode = MD_S_COMP; dec_num = num1; dec_den = den;
      end
    end
  end

  always_comb begin
    div_req.start = (state_r == ST_DECIDE) ||
                    (state_r == ST_DIV1 && div_rsp.done && mode_r == MD_BOTH);
    div_req.num   = (state_r == ST_DECIDE) ? dec_num : t_r;
    div_req.den   = (state_r == ST_DECIDE) ? dec_den : det_r;
  end

  // point capture and the final compare
  always_comb begin
    case (step_r)
      5'd3:    cap_c = 2'd0;
      5'd6:    cap_c = 2'd1;
      default: cap_c = 2'd2;
    endcase
    q_cap  = pick(XW'(q_r[0]), XW'(q_r[1]), XW'(q_r[2]), cap_c);
    nr_new = sat_pt(acc);
    df_new = (OW+1)'(nr_new) - (OW+1)'(q_cap <<< 8);
    dist_new  = (|acc[ACCW-1:DSW]) ? DIST_MAX : acc[DSW-1:0];
    better    = dist_new < best_d_r;
    nb_d      = better ? dist_new : best_d_r;
    fin_block = last_r && out_valid_r && !out_res.ready;
    emit      = (state_r == ST_PLACE) && (step_r == PLACE_LAST) && last_r && !fin_block;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      out_d_r     <= '0;
      out_x_r     <= '0;
      out_y_r     <= '0;
      out_z_r     <= '0;
      best_d_r    <= DIST_MAX;
      best_x_r    <= '0;
      best_y_r    <= '0;
      best_z_r    <= '0;
      q_r[0]      <= '0;
      q_r[1]      <= '0;
      q_r[2]      <= '0;
    end else begin
      if (cfg_wr.valid) begin
        unique case (cfg_wr.index)
          REG_QX:  q_r[0] <= cfg_wr.data;
          REG_QY:  q_r[1] <= cfg_wr.data;
          REG_QZ:  q_r[2] <= cfg_wr.data;
          default: ;
        endcase
      end
      if (out_valid_r && out_res.ready && !emit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_DOT;
            step_r  <= '0;
          end
        end
        ST_DOT: begin
          if (step_r == DOT_LAST) begin
            state_r <= ST_DECIDE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_DECIDE: state_r <= ST_DIV1;
        ST_DIV1: begin
          if (div_rsp.done) begin
            state_r <= (mode_r == MD_BOTH) ? ST_DIV2 : ST_PLACE;
            step_r  <= '0;
          end
        end
        ST_DIV2: begin
          if (div_rsp.done) begin
            state_r <= ST_PLACE;
            step_r  <= '0;
          end
        end
        ST_PLACE: begin
          if (step_r != PLACE_LAST) begin
            step_r <= step_r + 1'b1;
          end else if (!fin_block) begin
            // hold the last word until the old one has gone
            if (last_r) begin
              out_valid_r <= 1'b1;
              out_d_r     <= nb_d;
              out_x_r     <= better ? nr_r[0] : best_x_r;
              out_y_r     <= better ? nr_r[1] : best_y_r;
              out_z_r     <= better ? nr_r[2] : best_z_r;
              best_d_r    <= DIST_MAX;
              best_x_r    <= '0;
              best_y_r    <= '0;
              best_z_r    <= '0;
            end else if (better) begin
              best_d_r <= dist_new;
              best_x_r <= nr_r[0];
              best_y_r <= nr_r[1];
              best_z_r <= nr_r[2];
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      last_r  <= in_tri.last_triangle;
      p_r[0]  <= EW'(in_tri.a_x);
      p_r[1]  <= EW'(in_tri.a_y);
      p_r[2]  <= EW'(in_tri.a_z);
      e0_r[0] <= EW'(in_tri.b_x) - EW'(in_tri.a_x);
      e0_r[1] <= EW'(in_tri.b_y) - EW'(in_tri.a_y);
      e0_r[2] <= EW'(in_tri.b_z) - EW'(in_tri.a_z);
      e1_r[0] <= EW'(in_tri.c_x) - EW'(in_tri.a_x);
      e1_r[1] <= EW'(in_tri.c_y) - EW'(in_tri.a_y);
      e1_r[2] <= EW'(in_tri.c_z) - EW'(in_tri.a_z);
      v_r[0]  <= EW'(in_tri.a_x) - EW'(q_r[0]);
      v_r[1]  <= EW'(in_tri.a_y) - EW'(q_r[1]);
      v_r[2]  <= EW'(in_tri.a_z) - EW'(q_r[2]);
    end
    if (state_r == ST_DOT) begin
      case (step_r)
        5'd3:    a_r   <= acc[DOTW-1:0];
        5'd6:    b_r   <= acc[DOTW-1:0];
        5'd9:    c_r   <= acc[DOTW-1:0];
        5'd12:   d_r   <= acc[DOTW-1:0];
        5'd15:   e_r   <= acc[DOTW-1:0];
        5'd19:   det_r <= acc;
        5'd23:   s_r   <= acc;
        5'd27:   t_r   <= acc;
        default: ;
      endcase
    end
    if (state_r == ST_DECIDE) begin
      mode_r <= dec_mode;
    end
    if (state_r == ST_DIV1 && div_rsp.done) begin
      case (mode_r)
        MD_S_ONLY: begin sq_r <= div_rsp.q; tq_r <= '0; end
        MD_T_ONLY: begin sq_r <= '0; tq_r <= div_rsp.q; end
        MD_S_COMP: begin sq_r <= div_rsp.q; tq_r <= ONE_Q16 - div_rsp.q; end
        MD_T_COMP: begin tq_r <= div_rsp.q; sq_r <= ONE_Q16 - div_rsp.q; end
        default:   f1_r <= div_rsp.q;
      endcase
    end
    if (state_r == ST_DIV2 && div_rsp.done) begin
      sq_r <= f1_r;
      tq_r <= div_rsp.q;
    end
    if (state_r == ST_PLACE &&
        (step_r == 5'd3 || step_r == 5'd6 || step_r == 5'd9)) begin
      nr_r[cap_c] <= nr_new;
      df_r[cap_c] <= df_new;
    end
  end

endmodule

// ===== src/cptm_chk.sv =====
// ----------------------------------------------------------------------------
// cptm_chk: port-level checks for the closest-point block
// Watches the channel handshakes and result words, bound to the top level.
// ----------------------------------------------------------------------------
module cptm_chk import cptm_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [OW-1:0] near_x,
  input logic signed [OW-1:0] near_y,
  input logic signed [OW-1:0] near_z,
  input logic [DSW-1:0]       dist_squared
);

  // three squared Q8.16 differences never exceed this
  localparam logic [DSW-1:0] DIST_BOUND = 52'h3000000000000;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(dist_squared) &&
      $stable(near_x) && $stable(near_y) && $stable(near_z))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("triangle taken while a triangle is in progress");

  a_no_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !$rose(out_valid))
    else $error("result raised one cycle after a triangle");

  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> dist_squared <= DIST_BOUND)
    else $error("result distance out of range, minimum not tracked");

endmodule

bind closest_point_on_triangle_mesh cptm_chk u_cptm_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_tri.valid),
  .in_ready     (in_tri.ready),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .near_x       (out_res.near_x),
  .near_y       (out_res.near_y),
  .near_z       (out_res.near_z),
  .dist_squared (out_res.dist_squared)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for closest_point_on_triangle_mesh
// Streams triangle meshes against several query points, folds each accepted
// triangle into an own running nearest-point tracker and compares every
// emitted point and squared distance with it, under varied idling.
// ----------------------------------------------------------------------------
module tb;
  import cptm_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] vtx [9];
    logic                 last;
  } tri_word_t;

  typedef struct {
    logic signed [OW-1:0] near_x, near_y, near_z;
    logic [DSW-1:0]       dist_squared;
  } near_word_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 200;

  logic clk;
  logic rst_n;

  cptm_cfg_if cfg_wr ();
  cptm_tri_if in_tri ();
  cptm_res_if out_res ();

  closest_point_on_triangle_mesh u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .in_tri (in_tri),
    .out_res(out_res)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // nearest-point tracker state
  logic signed [CW-1:0] query [3];
  longint               best_dist;
  longint               best_pt [3];
  near_word_t           nearest_q [$];

  int sender_idle_pct;
  int receiver_stall_pct;
  int error_count;
  int quiet_cycles;

  function automatic longint qfrac(input wide_t n, input wide_t m);
    wide_t quo;
    if (m <= 0 || n <= 0) return 0;
    if (n >= m) return 65536;
    quo = (n * 65536) / m;
    return longint'(quo);
  endfunction

  function automatic bit fold_triangle(input tri_word_t tw, output near_word_t nw);
    longint p [3], e0 [3], e1 [3], v [3], qp [3], nr [3];
    longint a, b, c, d, e, den, sq, tq, acc, df, sq_dist;
    wide_t  det, s, t;
    a = 0; b = 0; c = 0; d = 0; e = 0; sq_dist = 0;
    for (int i = 0; i < 3; i++) begin
      qp[i] = longint'(query[i]);
      p[i]  = longint'(tw.vtx[i]);
      e0[i] = longint'(tw.vtx[3+i]) - p[i];
      e1[i] = longint'(tw.vtx[6+i]) - p[i];
      v[i]  = p[i] - qp[i];
      a += e0[i] * e0[i];
      b += e0[i] * e1[i];
      c += e1[i] * e1[i];
      d += e0[i] * v[i];
      e += e1[i] * v[i];
    end
    den = a - 2 * b + c;
    det = wide_t'(a) * wide_t'(c) - wide_t'(b) * wide_t'(b);
    s   = wide_t'(b) * wide_t'(e) - wide_t'(c) * wide_t'(d);
    t   = wide_t'(b) * wide_t'(d) - wide_t'(a) * wide_t'(e);
    if (s + t < det) begin
      if (s < 0) begin
        if (t < 0 && d < 0) begin
          sq = qfrac(wide_t'(-d), wide_t'(a)); tq = 0;
        end else begin
          sq = 0; tq = qfrac(wide_t'(-e), wide_t'(c));
        end
      end else if (t < 0) begin
        sq = qfrac(wide_t'(-d), wide_t'(a)); tq = 0;
      end else begin
        sq = qfrac(s, det); tq = qfrac(t, det);
      end
    end else begin
      if (s < 0) begin
        if (c + e > b + d) begin
          sq = qfrac(wide_t'((c + e) - (b + d)), wide_t'(den)); tq = 65536 - sq;
        end else begin
          sq = 0; tq = qfrac(wide_t'(-e), wide_t'(c));
        end
      end else if (t < 0) begin
        // published form of the t<0, s+t>=det region
        if (a + d > b + e) begin
          tq = qfrac(wide_t'((a + d) - (b + e)), wide_t'(den)); sq = 65536 - tq;
        end else begin
          tq = 0; sq = qfrac(wide_t'(-d), wide_t'(a));
        end
      end else begin
        sq = qfrac(wide_t'((c + e) - (b + d)), wide_t'(den)); tq = 65536 - sq;
      end
    end
    for (int i = 0; i < 3; i++) begin
      acc   = p[i] * 65536 + sq * e0[i] + tq * e1[i];
      nr[i] = acc >>> 8;
      if (nr[i] > 8388607) nr[i] = 8388607;
      if (nr[i] < -8388608) nr[i] = -8388608;
      df    = nr[i] - qp[i] * 256;
      sq_dist += df * df;
    end
    if (sq_dist > longint'(DIST_MAX)) sq_dist = longint'(DIST_MAX);
    // strictly smaller only: ties keep the earlier triangle
    if (sq_dist < best_dist) begin
      best_dist = sq_dist;
      for (int i = 0; i < 3; i++) best_pt[i] = nr[i];
    end
    if (!tw.last) return 1'b0;
    nw.near_x       = best_pt[0][OW-1:0];
    nw.near_y       = best_pt[1][OW-1:0];
    nw.near_z       = best_pt[2][OW-1:0];
    nw.dist_squared = best_dist[DSW-1:0];
    best_dist = longint'(DIST_MAX);
    for (int i = 0; i < 3; i++) best_pt[i] = 0;
    return 1'b1;
  endfunction

  // watch accepted words on every channel
  always @(posedge clk) begin
    tri_word_t  tw;
    near_word_t nw;
    near_word_t got;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        query[i] = '0; best_pt[i] = 0;
      end
      best_dist = longint'(DIST_MAX);
    end else begin
      if (cfg_wr.valid && cfg_wr.ready) begin
        case (cfg_wr.index)
          REG_QX: query[0] = cfg_wr.data;
          REG_QY: query[1] = cfg_wr.data;
          REG_QZ: query[2] = cfg_wr.data;
          default: ;
        endcase
      end
      if (in_tri.valid && in_tri.ready) begin
        tw.vtx[0] = in_tri.a_x; tw.vtx[1] = in_tri.a_y; tw.vtx[2] = in_tri.a_z;
        tw.vtx[3] = in_tri.b_x; tw.vtx[4] = in_tri.b_y; tw.vtx[5] = in_tri.b_z;
        tw.vtx[6] = in_tri.c_x; tw.vtx[7] = in_tri.c_y; tw.vtx[8] = in_tri.c_z;
        tw.last   = in_tri.last_triangle;
        if (fold_triangle(tw, nw)) nearest_q.push_back(nw);
      end
      if (out_res.valid && out_res.ready) begin
        if (nearest_q.size() == 0) begin
          $error("result word with no expectation waiting");
          error_count++;
        end else begin
          got = nearest_q.pop_front();
          if (out_res.near_x !== got.near_x) begin
            $error("near_x: expected %0d, got %0d", got.near_x, out_res.near_x);
            error_count++;
          end
          if (out_res.near_y !== got.near_y) begin
            $error("near_y: expected %0d, got %0d", got.near_y, out_res.near_y);
            error_count++;
          end
          if (out_res.near_z !== got.near_z) begin
            $error("near_z: expected %0d, got %0d", got.near_z, out_res.near_z);
            error_count++;
          end
          if (out_res.dist_squared !== got.dist_squared) begin
            $error("dist_squared: expected %0d, got %0d", got.dist_squared,
                   out_res.dist_squared);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tri.valid && in_tri.ready) || (out_res.valid && out_res.ready) ||
        (cfg_wr.valid && cfg_wr.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("closest_point_on_triangle_mesh: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk) begin
    out_res.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic send_triangle(input tri_word_t tw);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tri.valid <= 1'b0;
      @(negedge clk);
    end
    in_tri.valid <= 1'b1;
    in_tri.a_x <= tw.vtx[0]; in_tri.a_y <= tw.vtx[1]; in_tri.a_z <= tw.vtx[2];
    in_tri.b_x <= tw.vtx[3]; in_tri.b_y <= tw.vtx[4]; in_tri.b_z <= tw.vtx[5];
    in_tri.c_x <= tw.vtx[6]; in_tri.c_y <= tw.vtx[7]; in_tri.c_z <= tw.vtx[8];
    in_tri.last_triangle <= tw.last;
    do @(posedge clk); while (!in_tri.ready);
    @(negedge clk);
  endtask

  // drop valid, let every result drain, then let a non-final triangle finish
  task automatic wait_idle();
    in_tri.valid <= 1'b0;
    while (nearest_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_query(input int qx, input int qy, input int qz);
    logic [IW-1:0] idx [3];
    int            val [3];
    idx[0] = REG_QX; idx[1] = REG_QY; idx[2] = REG_QZ;
    val[0] = qx; val[1] = qy; val[2] = qz;
    wait_idle();
    for (int i = 0; i < 3; i++) begin
      cfg_wr.valid <= 1'b1;
      cfg_wr.index <= idx[i];
      cfg_wr.data  <= val[i][CW-1:0];
      do @(posedge clk); while (!cfg_wr.ready);
      @(negedge clk);
    end
    cfg_wr.valid <= 1'b0;
  endtask

  function automatic tri_word_t make_tri(input int ax, ay, az, bx, by, bz,
                                         cx, cy, cz, input bit last);
    tri_word_t tw;
    tw.vtx[0] = ax[CW-1:0]; tw.vtx[1] = ay[CW-1:0]; tw.vtx[2] = az[CW-1:0];
    tw.vtx[3] = bx[CW-1:0]; tw.vtx[4] = by[CW-1:0]; tw.vtx[5] = bz[CW-1:0];
    tw.vtx[6] = cx[CW-1:0]; tw.vtx[7] = cy[CW-1:0]; tw.vtx[8] = cz[CW-1:0];
    tw.last   = last;
    return tw;
  endfunction

  // mostly vertices scattered around the query point, some anywhere
  function automatic tri_word_t random_tri(input bit last);
    tri_word_t tw;
    int        span;
    bit        wild;
    wild = ($urandom_range(99) < 15);
    span = 1 << $urandom_range(14, 4);
    for (int i = 0; i < 9; i++) begin
      if (wild) tw.vtx[i] = CW'($urandom);
      else tw.vtx[i] = CW'(query[i % 3] + $urandom_range(2 * span) - span);
    end
    tw.last = last;
    return tw;
  endfunction

  task automatic test_directed();
    int big, neg;
    big = 32767; neg = -32768;
    // degenerate: all vertices equal, zero divisors everywhere
    send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_triangle(make_tri(256, 256, 256, 256, 256, 256, 256, 256, 256, 1'b1));
    // coordinate extremes
    send_triangle(make_tri(big, big, big, neg, neg, neg, big, neg, 0, 1'b1));
    send_triangle(make_tri(neg, neg, neg, neg, neg, neg, big, big, big, 1'b1));
    send_triangle(make_tri(big, neg, big, neg, big, neg, neg, neg, big, 1'b1));
    // collinear vertices
    send_triangle(make_tri(-512, -512, 0, 0, 0, 0, 512, 512, 0, 1'b1));
    // query inside, beyond each vertex and beyond each edge
    send_triangle(make_tri(-256, -256, 0, 512, -256, 0, -256, 512, 0, 1'b0));
    send_triangle(make_tri(256, 256, 0, 1024, 256, 0, 256, 1024, 0, 1'b0));
    send_triangle(make_tri(-1024, 256, 0, -256, 256, 0, -1024, 1024, 0, 1'b1));
    send_triangle(make_tri(256, -1024, 0, 1024, -1024, 0, 256, -256, 0, 1'b0));
    send_triangle(make_tri(-512, 256, 0, 256, -512, 0, 512, 512, 0, 1'b1));
    send_triangle(make_tri(-768, 256, 128, -256, -768, 0, 300, 900, -50, 1'b1));
    send_triangle(make_tri(100, 900, 0, 900, 100, 0, 1200, 1200, 0, 1'b1));
    // tie: identical triangles, the first one stays
    send_triangle(make_tri(300, 0, 100, 0, 300, 100, 300, 300, 100, 1'b0));
    send_triangle(make_tri(300, 0, 100, 0, 300, 100, 300, 300, 100, 1'b1));
    // tie with reordered vertices
    send_triangle(make_tri(0, 300, 100, 300, 300, 100, 300, 0, 100, 1'b0));
    send_triangle(make_tri(300, 300, 100, 300, 0, 100, 0, 300, 100, 1'b1));
    // closer triangle later in the mesh, then a farther one
    send_triangle(make_tri(4000, 4000, 4000, 5000, 4000, 4000, 4000, 5000, 4000, 1'b0));
    send_triangle(make_tri(10, 10, 10, 50, 10, 10, 10, 50, 10, 1'b0));
    send_triangle(make_tri(9000, 0, 0, 9500, 0, 0, 9000, 500, 0, 1'b1));
    // clearing: a lone far triangle right after a result
    send_triangle(make_tri(neg, 0, 0, neg, 100, 0, neg, 0, 100, 1'b1));
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    int sent, mesh_len;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    while (sent < count) begin
      mesh_len = ($urandom_range(9) == 0) ? $urandom_range(20, 10) : $urandom_range(6, 1);
      for (int k = 0; k < mesh_len; k++) send_triangle(random_tri(k == mesh_len - 1));
      sent += mesh_len;
    end
  endtask

  // hold the sender until every result is back, then carry on
  task automatic test_drain_pause();
    for (int m = 0; m < 4; m++) begin
      for (int k = 0; k < 3; k++) send_triangle(random_tri(k == 2));
      in_tri.valid <= 1'b0;
      while (nearest_q.size() != 0) @(negedge clk);
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    error_count          = 0;
    quiet_cycles         = 0;
    sender_idle_pct      = 0;
    receiver_stall_pct   = 0;
    cfg_wr.valid         = 1'b0;
    cfg_wr.index         = REG_QX;
    cfg_wr.data          = '0;
    in_tri.valid         = 1'b0;
    in_tri.a_x = '0; in_tri.a_y = '0; in_tri.a_z = '0;
    in_tri.b_x = '0; in_tri.b_y = '0; in_tri.b_z = '0;
    in_tri.c_x = '0; in_tri.c_y = '0; in_tri.c_z = '0;
    in_tri.last_triangle = 1'b0;
    out_res.ready        = 1'b1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    write_query(128, -64, 32);
    test_directed();
    test_random(400, 0, 0);
    write_query(32767, 32767, 32767);
    test_random(150, 59, 0);
    write_query(-32768, -32768, -32768);
    test_random(150, 0, 59);
    write_query(32767, -32768, 0);
    test_directed();
    test_random(150, 24, 24);
    test_drain_pause();
    write_query($urandom, $urandom, $urandom);
    test_random(350, 59, 0);
    write_query(-200, 700, -1500);
    test_random(300, 0, 59);
    write_query(0, 0, 0);
    test_random(200, 24, 24);

    wait_idle();
    if (error_count == 0) begin
      $display("closest_point_on_triangle_mesh: match");
    end else begin
      $display("closest_point_on_triangle_mesh: mismatch");
    end
    $finish;
  end

endmodule

// ===== closest_point_on_triangle_mesh.f =====
src/cptm_pkg.sv
src/cptm_ifs.sv
src/cptm_mac.sv
src/cptm_div.sv
src/closest_point_on_triangle_mesh.sv
src/cptm_chk.sv
test/tb.sv
